>>> design/bf_instruction_executor_assert.svh
// Assertion macros used by the executor's datapath.
`ifndef BF_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define BF_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Check an invariant on every clock edge outside reset.
`define BFIE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define BFIE_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define BFIE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/bfie_pkg.sv
// Package: sizes, character codes, microcode format and control ROM of the executor.
`timescale 1ns / 1ps

package bfie_pkg;

    localparam int PROG_DEPTH = 4096;
    localparam int TAPE_DEPTH = 8192;
    localparam int PA_W       = $clog2(PROG_DEPTH);
    localparam int PC_W       = $clog2(PROG_DEPTH + 1);
    localparam int TA_W       = $clog2(TAPE_DEPTH);
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int PC_OUT_W   = 13;

    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

    localparam logic OPC_LOAD = 1'b0;
    localparam logic OPC_STEP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_UNMATCHED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_EXEC,
        ACT_ADV,
        ACT_NEST,
        ACT_JUMP,
        ACT_FAIL,
        ACT_LOAD,
        ACT_CLEAR
    } t_act;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_REQ,
        C_LOAD,
        C_HALTED,
        C_NO_SCAN,
        C_EDGE,
        C_NEST_LIVE,
        C_OUT_FREE,
        C_CLR_LAST
    } t_cond;

    typedef logic [3:0] t_step;

    localparam t_step ST_IDLE   = 4'd0;
    localparam t_step ST_DECODE = 4'd1;
    localparam t_step ST_CHECK  = 4'd2;
    localparam t_step ST_EXEC   = 4'd3;
    localparam t_step ST_ADV    = 4'd4;
    localparam t_step ST_FETCH  = 4'd5;
    localparam t_step ST_CMP    = 4'd6;
    localparam t_step ST_FOUND  = 4'd7;
    localparam t_step ST_FAIL   = 4'd8;
    localparam t_step ST_REPLY  = 4'd9;
    localparam t_step ST_LOAD   = 4'd10;
    localparam t_step ST_CLEAR  = 4'd11;

    typedef struct packed {
        logic rdy;
        logic addr_pos;
        logic reply;
        t_act act;
    } t_ctrl;

    typedef struct packed {
        t_ctrl ctrl;
        t_cond cond;
        logic  hold;
        t_step tgt;
    } t_uword;

    typedef struct packed {
        logic is_load;
        logic halted;
        logic no_scan;
        logic at_edge;
        logic nest_live;
        logic clr_last;
    } t_flags;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                out_valid;
        logic                input_used;
        logic                halted;
        t_status             status;
        logic [PC_OUT_W-1:0] prog_counter;
    } t_result;

    function automatic t_uword uw(input logic rdy, input logic apos, input logic reply,
                                  input t_act act, input t_cond cond, input logic hold,
                                  input t_step tgt);
        t_uword w;
        w.ctrl.rdy      = rdy;
        w.ctrl.addr_pos = apos;
        w.ctrl.reply    = reply;
        w.ctrl.act      = act;
        w.cond          = cond;
        w.hold          = hold;
        w.tgt           = tgt;
        return w;
    endfunction

    // Control ROM: jump to tgt when cond holds, else hold or advance one step.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            ST_IDLE:   w = uw(1'b1, 1'b0, 1'b0, ACT_NONE,  C_REQ,       1'b1, ST_DECODE);
            ST_DECODE: w = uw(1'b0, 1'b0, 1'b0, ACT_NONE,  C_LOAD,      1'b0, ST_LOAD);
            ST_CHECK:  w = uw(1'b0, 1'b0, 1'b0, ACT_NONE,  C_HALTED,    1'b0, ST_REPLY);
            ST_EXEC:   w = uw(1'b0, 1'b0, 1'b0, ACT_EXEC,  C_NO_SCAN,   1'b0, ST_REPLY);
            ST_ADV:    w = uw(1'b0, 1'b1, 1'b0, ACT_ADV,   C_EDGE,      1'b0, ST_FAIL);
            ST_FETCH:  w = uw(1'b0, 1'b1, 1'b0, ACT_NONE,  C_ALWAYS,    1'b0, ST_CMP);
            ST_CMP:    w = uw(1'b0, 1'b1, 1'b0, ACT_NEST,  C_NEST_LIVE, 1'b0, ST_ADV);
            ST_FOUND:  w = uw(1'b0, 1'b0, 1'b0, ACT_JUMP,  C_ALWAYS,    1'b0, ST_REPLY);
            ST_FAIL:   w = uw(1'b0, 1'b0, 1'b0, ACT_FAIL,  C_ALWAYS,    1'b0, ST_REPLY);
            ST_REPLY:  w = uw(1'b0, 1'b0, 1'b1, ACT_NONE,  C_OUT_FREE,  1'b1, ST_IDLE);
            ST_LOAD:   w = uw(1'b0, 1'b0, 1'b0, ACT_LOAD,  C_ALWAYS,    1'b0, ST_REPLY);
            ST_CLEAR:  w = uw(1'b0, 1'b0, 1'b0, ACT_CLEAR, C_CLR_LAST,  1'b1, ST_IDLE);
            default:   w = uw(1'b0, 1'b0, 1'b0, ACT_NONE,  C_ALWAYS,    1'b0, ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

>>> design/bfie_if.sv
// Interfaces: request and response channels of the executor.
`timescale 1ns / 1ps

interface bfie_req_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [bfie_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output opcode, output data_byte, input ready);
    modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface bfie_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bfie_pkg::BYTE_W-1:0]   out_byte;
    logic                          out_valid;
    logic                          input_used;
    logic                          halted;
    logic [bfie_pkg::STATUS_W-1:0] status;
    logic [bfie_pkg::PC_OUT_W-1:0] prog_counter;

    modport source (output valid, output out_byte, output out_valid, output input_used,
                    output halted, output status, output prog_counter, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input input_used,
                    input halted, input status, input prog_counter, output ready);
endinterface

>>> design/bfie_sequencer.sv
// Sequencer: step counter, control ROM lookup and conditional jumps.
`timescale 1ns / 1ps

module bfie_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_out_free,
    input  bfie_pkg::t_flags i_flags,
    output bfie_pkg::t_ctrl  o_ctrl
);
    import bfie_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_take;

    assign w_word = ucode(r_step);
    assign o_ctrl = w_word.ctrl;

    always_comb begin
        unique case (w_word.cond)
            C_ALWAYS:    w_take = 1'b1;
            C_REQ:       w_take = i_req_valid;
            C_LOAD:      w_take = i_flags.is_load;
            C_HALTED:    w_take = i_flags.halted;
            C_NO_SCAN:   w_take = i_flags.no_scan;
            C_EDGE:      w_take = i_flags.at_edge;
            C_NEST_LIVE: w_take = i_flags.nest_live;
            C_OUT_FREE:  w_take = i_out_free;
            C_CLR_LAST:  w_take = i_flags.clr_last;
            default:     w_take = 1'b0;
        endcase
    end

    always_comb begin
        if (w_take) begin
            n_step = w_word.tgt;
        end else if (w_word.hold) begin
            n_step = r_step;
        end else begin
            n_step = t_step'(r_step + 4'd1);
        end
    end

    // Start with the tape clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> design/bfie_datapath.sv
// Datapath: program and tape memories, program counter, head and bracket scan registers.
`timescale 1ns / 1ps
`include "bf_instruction_executor_assert.svh"

module bfie_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfie_pkg::t_ctrl             i_ctrl,
    input  logic                        i_accept,
    input  logic                        i_opcode,
    input  logic [bfie_pkg::BYTE_W-1:0] i_data_byte,
    output bfie_pkg::t_flags            o_flags,
    output bfie_pkg::t_result           o_result
);
    import bfie_pkg::*;

    logic [BYTE_W-1:0] r_prog_mem [PROG_DEPTH];
    logic [BYTE_W-1:0] r_tape_mem [TAPE_DEPTH];
    logic [BYTE_W-1:0] r_prog_q;
    logic [BYTE_W-1:0] r_cell_q;

    logic [PC_W-1:0]   r_len,  n_len;
    logic [PC_W-1:0]   r_pc,   n_pc;
    logic [PC_W-1:0]   r_pos,  n_pos;
    logic [PC_W-1:0]   r_nest, n_nest;
    logic [TA_W-1:0]   r_head, n_head;
    logic [TA_W-1:0]   r_clr,  n_clr;
    logic              r_fwd,  n_fwd;
    logic              r_opcode, n_opcode;
    logic [BYTE_W-1:0] r_data, n_data;
    t_status           r_status, n_status;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_valid, n_out_valid;
    logic              r_in_used, n_in_used;

    logic [PA_W-1:0]   w_prog_raddr;
    logic              w_prog_we;
    logic              w_room;
    logic              w_is_open;
    logic              w_is_close;
    logic              w_cell_zero;
    logic              w_scan;
    logic [PC_W-1:0]   w_pos_inc;
    logic              w_at_edge;
    logic [BYTE_W-1:0] w_same;
    logic [BYTE_W-1:0] w_other;
    logic              w_nest_live;
    logic              w_clr_last;
    logic              w_tape_we;
    logic [TA_W-1:0]   w_tape_waddr;
    logic [BYTE_W-1:0] w_tape_wdata;

    assign w_prog_raddr = i_ctrl.addr_pos ? r_pos[PA_W-1:0] : r_pc[PA_W-1:0];
    assign w_room       = r_len < PC_W'(PROG_DEPTH);
    assign w_prog_we    = (i_ctrl.act == ACT_LOAD) && w_room;
    assign w_is_open    = r_prog_q == CH_OPEN;
    assign w_is_close   = r_prog_q == CH_CLOSE;
    assign w_cell_zero  = r_cell_q == '0;
    assign w_scan       = (w_is_open && w_cell_zero) || (w_is_close && !w_cell_zero);
    assign w_pos_inc    = r_pos + PC_W'(1);
    assign w_at_edge    = r_fwd ? (w_pos_inc >= r_len) : (r_pos == '0);
    assign w_same       = r_fwd ? CH_OPEN : CH_CLOSE;
    assign w_other      = r_fwd ? CH_CLOSE : CH_OPEN;
    assign w_nest_live  = !((r_prog_q == w_other) && (r_nest == PC_W'(1)));
    assign w_clr_last   = r_clr == TA_W'(TAPE_DEPTH - 1);

    // Tape write port: clearing pass or cell update.
    always_comb begin
        w_tape_we    = 1'b0;
        w_tape_waddr = r_head;
        w_tape_wdata = r_cell_q;
        if (i_ctrl.act == ACT_CLEAR) begin
            w_tape_we    = 1'b1;
            w_tape_waddr = r_clr;
            w_tape_wdata = '0;
        end else if (i_ctrl.act == ACT_EXEC) begin
            case (r_prog_q)
                CH_INC: begin
                    w_tape_we    = 1'b1;
                    w_tape_wdata = r_cell_q + 8'd1;
                end
                CH_DEC: begin
                    w_tape_we    = 1'b1;
                    w_tape_wdata = r_cell_q - 8'd1;
                end
                CH_IN: begin
                    w_tape_we    = 1'b1;
                    w_tape_wdata = r_data;
                end
                default: begin
                    w_tape_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_prog_we) begin
            r_prog_mem[r_len[PA_W-1:0]] <= r_data;
        end
        r_prog_q <= r_prog_mem[w_prog_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_tape_we) begin
            r_tape_mem[w_tape_waddr] <= w_tape_wdata;
        end
        r_cell_q <= r_tape_mem[r_head];
    end

    always_comb begin
        n_len       = r_len;
        n_pc        = r_pc;
        n_pos       = r_pos;
        n_nest      = r_nest;
        n_head      = r_head;
        n_clr       = r_clr;
        n_fwd       = r_fwd;
        n_opcode    = r_opcode;
        n_data      = r_data;
        n_status    = r_status;
        n_out_byte  = r_out_byte;
        n_out_valid = r_out_valid;
        n_in_used   = r_in_used;

        if (i_accept) begin
            n_opcode    = i_opcode;
            n_data      = i_data_byte;
            n_status    = STAT_OK;
            n_out_byte  = '0;
            n_out_valid = 1'b0;
            n_in_used   = 1'b0;
        end

        unique case (i_ctrl.act)
            ACT_EXEC: begin
                n_pc = r_pc + PC_W'(1);
                case (r_prog_q) inside
                    CH_RIGHT: begin
                        n_head = (r_head == TA_W'(TAPE_DEPTH - 1)) ? '0 : r_head + TA_W'(1);
                    end
                    CH_LEFT: begin
                        n_head = (r_head == '0) ? TA_W'(TAPE_DEPTH - 1) : r_head - TA_W'(1);
                    end
                    CH_OUT: begin
                        n_out_byte  = r_cell_q;
                        n_out_valid = 1'b1;
                    end
                    CH_IN: begin
                        n_in_used = 1'b1;
                    end
                    CH_OPEN, CH_CLOSE: begin
                        // Start a scan from the bracket itself.
                        if (w_scan) begin
                            n_pc   = r_pc;
                            n_pos  = r_pc;
                            n_nest = PC_W'(1);
                            n_fwd  = w_is_open;
                        end
                    end
                    default: begin
                        n_pc = r_pc + PC_W'(1);
                    end
                endcase
            end
            ACT_ADV: begin
                if (!w_at_edge) begin
                    n_pos = r_fwd ? w_pos_inc : r_pos - PC_W'(1);
                end
            end
            ACT_NEST: begin
                if (r_prog_q == w_same) begin
                    n_nest = r_nest + PC_W'(1);
                end else if (r_prog_q == w_other) begin
                    n_nest = r_nest - PC_W'(1);
                end
            end
            ACT_JUMP: begin
                n_pc   = r_pos;
                n_nest = '0;
            end
            ACT_FAIL: begin
                n_pc     = r_len;
                n_nest   = '0;
                n_status = STAT_UNMATCHED;
            end
            ACT_LOAD: begin
                if (w_room) begin
                    n_len = r_len + PC_W'(1);
                end else begin
                    n_status = STAT_FULL;
                end
            end
            ACT_CLEAR: begin
                n_clr = w_clr_last ? '0 : r_clr + TA_W'(1);
            end
            ACT_NONE: begin
                n_clr = r_clr;
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_pc   <= '0;
            r_nest <= '0;
            r_head <= TA_W'(TAPE_DEPTH / 2);
            r_clr  <= '0;
        end else begin
            r_len  <= n_len;
            r_pc   <= n_pc;
            r_nest <= n_nest;
            r_head <= n_head;
            r_clr  <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_fwd       <= n_fwd;
        r_opcode    <= n_opcode;
        r_data      <= n_data;
        r_status    <= n_status;
        r_out_byte  <= n_out_byte;
        r_out_valid <= n_out_valid;
        r_in_used   <= n_in_used;
    end

    assign o_flags.is_load   = r_opcode == OPC_LOAD;
    assign o_flags.halted    = r_pc >= r_len;
    assign o_flags.no_scan   = !((w_is_open || w_is_close) && w_scan);
    assign o_flags.at_edge   = w_at_edge;
    assign o_flags.nest_live = w_nest_live;
    assign o_flags.clr_last  = w_clr_last;

    assign o_result.out_byte     = r_out_byte;
    assign o_result.out_valid    = r_out_valid;
    assign o_result.input_used   = r_in_used;
    assign o_result.halted       = r_pc >= r_len;
    assign o_result.status       = r_status;
    assign o_result.prog_counter = PC_OUT_W'(r_pc);

    `BFIE_ASSERT(a_pc_in_prog, r_pc <= r_len, "program counter beyond program end")
    `BFIE_ASSERT(a_head_range, int'(r_head) < TAPE_DEPTH, "tape head out of range")
    `BFIE_ASSERT_IMPLY(a_nest_clear, i_ctrl.act == ACT_EXEC, r_nest == '0, "scan depth not cleared")
    `BFIE_ASSERT_IMPLY(a_scan_in_prog, i_ctrl.act == ACT_NEST, r_pos < r_len, "scan left program")
    `BFIE_ASSERT_NEXT(a_load_grows, (i_ctrl.act == ACT_LOAD) && w_room, r_len == $past(r_len) + PC_W'(1), "load lost")

endmodule

>>> design/bf_instruction_executor.sv
// Steps: a load runs decode and load; a step runs decode, check and, unless halted, execute; a
// bracket jump then loops through advance, fetch and compare, ending in found or in fail.
// Each request ends in the reply step; a new one is accepted only back at the idle step, so
// no request starts before the last is processed; program memory has a single registered read port.
// Reset: synchronous, active low; a clearing pass then zeroes the tape, one cell per cycle over
// all TAPE_DEPTH cells, during which no request is accepted.
`timescale 1ns / 1ps

module bf_instruction_executor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfie_req_if.sink    i_req,
    bfie_rsp_if.source  o_rsp
);
    import bfie_pkg::*;

    t_ctrl   w_ctrl;
    t_flags  w_flags;
    t_result w_result;
    logic    w_accept;
    logic    w_out_free;
    logic    w_load_rsp;
    logic    r_rsp_valid;
    t_result r_rsp;

    // Requests enter only at the idle step of the microprogram.
    assign i_req.ready = w_ctrl.rdy;
    assign w_accept    = i_req.valid && w_ctrl.rdy;

    // The response register frees up in the cycle its content is taken,
    // so the next request may start while a response still waits.
    assign w_out_free = !r_rsp_valid || o_rsp.ready;
    assign w_load_rsp = w_ctrl.reply && w_out_free;

    bfie_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_out_free  (w_out_free),
        .i_flags     (w_flags),
        .o_ctrl      (w_ctrl)
    );

    bfie_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_accept    (w_accept),
        .i_opcode    (i_req.opcode),
        .i_data_byte (i_req.data_byte),
        .o_flags     (w_flags),
        .o_result    (w_result)
    );

    // Hold the response until the sink takes it; drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_load_rsp) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_rsp) begin
            r_rsp <= w_result;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.out_byte     = r_rsp.out_byte;
    assign o_rsp.out_valid    = r_rsp.out_valid;
    assign o_rsp.input_used   = r_rsp.input_used;
    assign o_rsp.halted       = r_rsp.halted;
    assign o_rsp.status       = r_rsp.status;
    assign o_rsp.prog_counter = r_rsp.prog_counter;

endmodule

>>> test/bfie_exec_checker.sv
// Checker for the tape-language executor: predicts every response and compares it field by field.
`timescale 1ns / 1ps

module bfie_exec_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bfie_req_if  i_req,
    bfie_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import bfie_pkg::*;

    logic [BYTE_W-1:0] prog_mem [PROG_DEPTH];
    logic [BYTE_W-1:0] tape [TAPE_DEPTH];
    int unsigned       prog_len;
    int unsigned       pc;
    int unsigned       head;
    t_result           expected_q [$];
    int                fail_count = 0;
    int                rsp_count = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("checker: response %0d: %s", rsp_count, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic reset_model();
        foreach (tape[i]) tape[i] = '0;
        prog_len = 0;
        pc       = 0;
        head     = TAPE_DEPTH / 2;
        expected_q.delete();
    endtask

    // Scan from pc for the partner bracket, counting nesting; fail past either end.
    function automatic bit find_partner(input bit forward, output int unsigned where);
        int unsigned       pos;
        int unsigned       depth;
        logic [BYTE_W-1:0] same_ch;
        logic [BYTE_W-1:0] other_ch;
        pos      = pc;
        same_ch  = forward ? CH_OPEN : CH_CLOSE;
        other_ch = forward ? CH_CLOSE : CH_OPEN;
        depth    = 1;
        where    = 0;
        while (depth != 0) begin
            if (forward) begin
                if (pos + 1 >= prog_len) return 1'b0;
                pos++;
            end else begin
                if (pos == 0) return 1'b0;
                pos--;
            end
            if (prog_mem[PA_W'(pos)] == same_ch) depth++;
            else if (prog_mem[PA_W'(pos)] == other_ch) depth--;
        end
        where = pos;
        return 1'b1;
    endfunction

    task automatic execute_request(input logic opc, input logic [BYTE_W-1:0] data,
                                   output t_result res);
        logic [BYTE_W-1:0] ch;
        int unsigned       target;
        int unsigned       next_pc;
        res        = '0;
        res.status = STAT_OK;
        if (opc == OPC_LOAD) begin
            if (prog_len < PROG_DEPTH) begin
                prog_mem[PA_W'(prog_len)] = data;
                prog_len++;
            end else begin
                res.status = STAT_FULL;
            end
        end else if (pc < prog_len) begin
            ch      = prog_mem[PA_W'(pc)];
            next_pc = pc + 1;
            case (ch)
                CH_RIGHT: head = (head + 1) % TAPE_DEPTH;
                CH_LEFT:  head = (head + TAPE_DEPTH - 1) % TAPE_DEPTH;
                CH_INC:   tape[TA_W'(head)] = tape[TA_W'(head)] + 8'd1;
                CH_DEC:   tape[TA_W'(head)] = tape[TA_W'(head)] - 8'd1;
                CH_OUT: begin
                    res.out_byte  = tape[TA_W'(head)];
                    res.out_valid = 1'b1;
                end
                CH_IN: begin
                    tape[TA_W'(head)] = data;
                    res.input_used    = 1'b1;
                end
                CH_OPEN, CH_CLOSE: begin
                    if ((ch == CH_OPEN) == (tape[TA_W'(head)] == 8'd0)) begin
                        if (find_partner(ch == CH_OPEN, target)) begin
                            next_pc = target;
                        end else begin
                            res.status = STAT_UNMATCHED;
                            next_pc    = prog_len;
                        end
                    end
                end
                default: ;
            endcase
            pc = next_pc;
        end
        res.halted       = (pc >= prog_len);
        res.prog_counter = PC_OUT_W'(pc);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                rsp_count++;
                if (expected_q.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = expected_q.pop_front();
                    check_field("out_byte", 16'(i_rsp.out_byte), 16'(want.out_byte));
                    check_field("out_valid", 16'(i_rsp.out_valid), 16'(want.out_valid));
                    check_field("input_used", 16'(i_rsp.input_used), 16'(want.input_used));
                    check_field("halted", 16'(i_rsp.halted), 16'(want.halted));
                    check_field("status", 16'(i_rsp.status), 16'(want.status));
                    check_field("prog_counter", 16'(i_rsp.prog_counter),
                                16'(want.prog_counter));
                end
            end
            if (i_req.valid && i_req.ready) begin
                execute_request(i_req.opcode, i_req.data_byte, want);
                expected_q.insert(expected_q.size(), want);
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> test/testbench.sv
// Testbench top: drives load and step requests into the executor and gives the verdict.
`timescale 1ns / 1ps

module testbench;
    import bfie_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 40;

    // Commands that never jump; brackets are placed only in shapes that terminate.
    localparam logic [BYTE_W-1:0] PLAIN_CMDS [6] = '{CH_RIGHT, CH_LEFT, CH_INC,
                                                     CH_DEC, CH_OUT, CH_IN};

    logic i_clk;
    logic i_rst_n;

    bfie_req_if req_ch ();
    bfie_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int cycle_count = 0;
    int items_sent  = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;

    logic [BYTE_W-1:0] snippet [$];

    bf_instruction_executor u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bfie_exec_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Abort a run that hangs; the limit is far above the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Gap length for either side: mostly none, often short, now and then long.
    // A calm stretch turns idling off on both sides.
    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = int'($urandom_range(99));
        if (roll < 60) return 0;
        if (roll < 92) return int'($urandom_range(3, 1));
        return int'($urandom_range(40, 8));
    endfunction

    // Stall the response side: hold ready low for a picked number of cycles, then raise it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    // Any byte except the brackets, so that noise cannot open or close a loop.
    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [BYTE_W-1:0] b;
        do begin
            b = BYTE_W'($urandom_range(255));
        end while (b == CH_OPEN || b == CH_CLOSE);
        return b;
    endfunction

    // Byte for a step request: small values keep loops short, full range now and then.
    function automatic logic [BYTE_W-1:0] step_byte();
        if ($urandom_range(99) < 85) return BYTE_W'($urandom_range(6));
        return BYTE_W'($urandom_range(255));
    endfunction

    function automatic logic [BYTE_W-1:0] plain_or_noise();
        if ($urandom_range(7) == 0) return noise_byte();
        return PLAIN_CMDS[3'($urandom_range(5))];
    endfunction

    // Present one request, optionally after an idle gap, and hold it until accepted.
    task automatic send_request(input logic opc, input logic [BYTE_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= opc;
        req_ch.data_byte <= data;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic load_then_step(input logic [BYTE_W-1:0] ch,
                                  input logic [BYTE_W-1:0] data);
        send_request(OPC_LOAD, ch);
        send_request(OPC_STEP, data);
    endtask

    // Append one character to the fragment.
    task automatic add_cmd(input logic [BYTE_W-1:0] ch);
        snippet.insert(snippet.size(), ch);
    endtask

    // Fill the snippet queue with one program fragment of a random shape.
    task automatic build_snippet();
        int roll;
        int reps;
        roll = int'($urandom_range(99));
        snippet.delete();
        if (roll < 50) begin
            // Counted loop: seed the cell, then a body that always walks it down to zero.
            if ($urandom_range(1)) begin
                add_cmd(CH_IN);
            end else begin
                reps = int'($urandom_range(3, 1));
                repeat (reps) add_cmd(CH_INC);
            end
            add_cmd(CH_OPEN);
            case ($urandom_range(4))
                0: add_cmd(CH_DEC);
                1: begin
                    add_cmd(CH_DEC);
                    add_cmd(CH_OUT);
                end
                2: begin
                    add_cmd(CH_DEC);
                    add_cmd(CH_RIGHT);
                    reps = int'($urandom_range(3, 1));
                    repeat (reps) add_cmd(CH_INC);
                    add_cmd(CH_LEFT);
                end
                3: begin
                    add_cmd(CH_DEC);
                    add_cmd(CH_LEFT);
                    add_cmd(CH_INC);
                    add_cmd(CH_RIGHT);
                    add_cmd(CH_OUT);
                end
                default: begin
                    // Nested loop: clear the neighbor cell on every pass.
                    add_cmd(CH_RIGHT);
                    add_cmd(CH_OPEN);
                    add_cmd(CH_DEC);
                    add_cmd(CH_CLOSE);
                    add_cmd(CH_LEFT);
                    add_cmd(CH_DEC);
                end
            endcase
            add_cmd(CH_CLOSE);
        end else if (roll < 80) begin
            reps = int'($urandom_range(8, 1));
            repeat (reps) add_cmd(plain_or_noise());
        end else if (roll < 90) begin
            reps = int'($urandom_range(4, 1));
            repeat (reps) add_cmd(noise_byte());
        end else begin
            // Broken shapes: clear the cell, then a lone open (forward scan fails and
            // halts until more is loaded) or a stray close on a zero cell.
            add_cmd(CH_OPEN);
            add_cmd(CH_DEC);
            add_cmd(CH_CLOSE);
            add_cmd($urandom_range(1) ? CH_OPEN : CH_CLOSE);
        end
    endtask

    // Load the fragment, then step through it; loops may spill over into the next round.
    task automatic run_snippet();
        int steps;
        foreach (snippet[i]) send_request(OPC_LOAD, snippet[i]);
        steps = int'(snippet.size() * $urandom_range(4, 1) + $urandom_range(6));
        repeat (steps) send_request(OPC_STEP, step_byte());
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= OPC_LOAD;
        req_ch.data_byte <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Step on an empty program: nothing runs, halted.
        send_request(OPC_STEP, 8'h00);
        // Close on a nonzero cell with no open bracket before it: backward scan fails.
        load_then_step(CH_INC, 8'h00);
        load_then_step(CH_CLOSE, 8'h00);
        // Step while halted.
        send_request(OPC_STEP, 8'hFF);
        // Wrap the cell down to 255, emit it, wrap it back up to zero.
        load_then_step(CH_DEC, 8'h00);
        load_then_step(CH_DEC, 8'h00);
        load_then_step(CH_OUT, 8'h00);
        load_then_step(CH_INC, 8'h00);
        // Open on a zero cell with no partner loaded: forward scan fails.
        load_then_step(CH_OPEN, 8'h00);
        // Resume after more is loaded: read an all-ones byte, move the head both ways.
        load_then_step(CH_IN, 8'hFF);
        load_then_step(CH_LEFT, 8'h00);
        load_then_step(CH_RIGHT, 8'h00);
        load_then_step(CH_OUT, 8'h00);
        // Characters outside the command set are skipped.
        load_then_step(8'h00, 8'h00);
        load_then_step(8'hFF, 8'hAA);

        // Random part: mostly well-formed fragments with random content.
        while (items_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(9) == 0);
            build_snippet();
            run_snippet();
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        // Drain: let the outstanding count settle, then wait for every response.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/bfie_pkg.sv
design/bfie_if.sv
design/bfie_sequencer.sv
design/bfie_datapath.sv
design/bf_instruction_executor.sv
test/bfie_exec_checker.sv
test/testbench.sv
